[hdl/frame_coordinate_transform_macros.svh]
// assertion macros shared by the frame coordinate transform modules
`ifndef FRAME_COORDINATE_TRANSFORM_MACROS_SVH
`define FRAME_COORDINATE_TRANSFORM_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define FCT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fct_pkg.sv]
// shared types, constants and helpers for the frame coordinate transform
package fct_pkg;

   // number formats
   localparam int COORD_WIDTH     = 32;
   localparam int AXIS_BITS       = 18;
   localparam int AXIS_FRAC       = 16;
   localparam int AXIS_PACK_WIDTH = 3 * AXIS_BITS;
   localparam int OPND_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = OPND_WIDTH + AXIS_BITS;
   localparam int DOT_WIDTH       = 2 * AXIS_BITS;
   localparam int SUM_WIDTH       = PROD_WIDTH + 2;
   localparam int ACC_WIDTH       = SUM_WIDTH - AXIS_FRAC + 1;
   localparam int TOL_WIDTH       = 16;
   localparam int CMD_WIDTH       = 3;
   localparam int OP_WIDTH        = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // command codes
   localparam logic [CMD_WIDTH-1:0] CMD_W2L_POINT  = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_L2W_POINT  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_W2L_VECTOR = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_L2W_VECTOR = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_CHECK      = 3'd4;

   // operation classes handed from front to back
   localparam logic [OP_WIDTH-1:0] OP_NONE  = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_W2L   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_L2W   = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_CHECK = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_X   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_Y   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_Z   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ORIGIN_Z = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TOL      = 3'd6;

   // register reset values: identity frame
   localparam logic [AXIS_PACK_WIDTH-1:0] AXIS_X_RESET =
      AXIS_PACK_WIDTH'(1) << AXIS_FRAC;
   localparam logic [AXIS_PACK_WIDTH-1:0] AXIS_Y_RESET =
      AXIS_PACK_WIDTH'(1) << (AXIS_FRAC + AXIS_BITS);
   localparam logic [AXIS_PACK_WIDTH-1:0] AXIS_Z_RESET =
      AXIS_PACK_WIDTH'(1) << (AXIS_FRAC + 2 * AXIS_BITS);
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd64;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]          cmd;
      logic signed [COORD_WIDTH-1:0] in_x;
      logic signed [COORD_WIDTH-1:0] in_y;
      logic signed [COORD_WIDTH-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic                          saturated;
      logic                          is_orthonormal;
   } rsp_type;

   typedef struct packed {
      logic [AXIS_PACK_WIDTH-1:0]    axis_x;
      logic [AXIS_PACK_WIDTH-1:0]    axis_y;
      logic [AXIS_PACK_WIDTH-1:0]    axis_z;
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] origin_z;
      logic [TOL_WIDTH-1:0]          tol;
   } cfg_type;

   // classified item waiting between front and back
   typedef struct packed {
      logic [OP_WIDTH-1:0]          op;
      logic                         add_origin;
      logic signed [OPND_WIDTH-1:0] opnd_x;
      logic signed [OPND_WIDTH-1:0] opnd_y;
      logic signed [OPND_WIDTH-1:0] opnd_z;
   } work_type;

   // one signed Q1.16 component of a packed axis
   function automatic logic signed [AXIS_BITS-1:0] axis_comp(
      input logic [AXIS_PACK_WIDTH-1:0] packed_axis,
      input logic [1:0]                 comp
   );
      axis_comp = $signed(packed_axis[AXIS_BITS * comp +: AXIS_BITS]);
   endfunction

endpackage

[hdl/fct_csr.sv]
// configuration registers of the frame coordinate transform
module fct_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fct_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fct_pkg::AXIS_PACK_WIDTH-1:0]  csr_wdata,
   output fct_pkg::cfg_type                     cfg
);
   import fct_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_AXIS_X:   cfg_in.axis_x   = csr_wdata;
            REG_AXIS_Y:   cfg_in.axis_y   = csr_wdata;
            REG_AXIS_Z:   cfg_in.axis_z   = csr_wdata;
            REG_ORIGIN_X: cfg_in.origin_x = $signed(csr_wdata[COORD_WIDTH-1:0]);
            REG_ORIGIN_Y: cfg_in.origin_y = $signed(csr_wdata[COORD_WIDTH-1:0]);
            REG_ORIGIN_Z: cfg_in.origin_z = $signed(csr_wdata[COORD_WIDTH-1:0]);
            REG_TOL:      cfg_in.tol      = csr_wdata[TOL_WIDTH-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{axis_x:   AXIS_X_RESET,
                     axis_y:   AXIS_Y_RESET,
                     axis_z:   AXIS_Z_RESET,
                     origin_x: '0,
                     origin_y: '0,
                     origin_z: '0,
                     tol:      TOL_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/fct_front.sv]
// front end: accepts request words, classifies the command, removes the origin from world-to-local points
module fct_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  fct_pkg::req_type    req_data,
   input  fct_pkg::cfg_type    cfg,
   input  logic                work_full,
   output logic                work_valid,
   output fct_pkg::work_type   work_data
);
   import fct_pkg::*;

   logic     f_valid_ff;
   logic     f_valid_in;
   work_type f_data_ff;
   work_type f_data_in;
   logic     take;

   // stall only while holding a word the queue cannot take
   assign req_stall  = f_valid_ff && work_full;
   assign take       = req_valid && !req_stall;
   assign work_valid = f_valid_ff;
   assign work_data  = f_data_ff;

   // classify the command and form the multiplier operands
   always_comb begin
      f_data_in            = f_data_ff;
      if (take) begin
         f_data_in.add_origin = 1'b0;
         f_data_in.opnd_x     = OPND_WIDTH'($signed(req_data.in_x));
         f_data_in.opnd_y     = OPND_WIDTH'($signed(req_data.in_y));
         f_data_in.opnd_z     = OPND_WIDTH'($signed(req_data.in_z));
         case (req_data.cmd)
            CMD_W2L_POINT: begin
               f_data_in.op     = OP_W2L;
               f_data_in.opnd_x = OPND_WIDTH'($signed(req_data.in_x))
                                - OPND_WIDTH'($signed(cfg.origin_x));
               f_data_in.opnd_y = OPND_WIDTH'($signed(req_data.in_y))
                                - OPND_WIDTH'($signed(cfg.origin_y));
               f_data_in.opnd_z = OPND_WIDTH'($signed(req_data.in_z))
                                - OPND_WIDTH'($signed(cfg.origin_z));
            end
            CMD_W2L_VECTOR: begin
               f_data_in.op = OP_W2L;
            end
            CMD_L2W_POINT: begin
               f_data_in.op         = OP_L2W;
               f_data_in.add_origin = 1'b1;
            end
            CMD_L2W_VECTOR: begin
               f_data_in.op = OP_L2W;
            end
            CMD_CHECK: begin
               f_data_in.op     = OP_CHECK;
               f_data_in.opnd_x = '0;
               f_data_in.opnd_y = '0;
               f_data_in.opnd_z = '0;
            end
            default: begin
               f_data_in.op     = OP_NONE;
               f_data_in.opnd_x = '0;
               f_data_in.opnd_y = '0;
               f_data_in.opnd_z = '0;
            end
         endcase
      end
   end

   // holding register valid
   always_comb begin
      if (take) begin
         f_valid_in = 1'b1;
      end else if (!work_full) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_data_ff <= f_data_in;
   end

endmodule

[hdl/fct_queue.sv]
// short queue of classified words between front and back
`include "frame_coordinate_transform_macros.svh"

module fct_queue #(
   parameter int QUEUE_DEPTH = fct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                full,
   input  fct_pkg::work_type   push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fct_pkg::work_type   pop_data
);
   import fct_pkg::*;

   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_PTR    = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] DEPTH_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   work_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign full      = (count_ff == DEPTH_COUNT);
   assign pop_valid = (count_ff != '0);
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + COUNT_WIDTH'(push) - COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `FCT_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= DEPTH_COUNT, "queue count above depth")
   `FCT_ASSERT_NEXT(a_count_down, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count did not fall on pop")
   `FCT_ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise on push")

endmodule

[hdl/fct_back.sv]
// back end: product stage, sum and saturate stage, response register
`include "frame_coordinate_transform_macros.svh"

module fct_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   output logic                work_ready,
   input  fct_pkg::work_type   work_data,
   input  fct_pkg::cfg_type    cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fct_pkg::rsp_type    rsp_data
);
   import fct_pkg::*;

   logic signed [AXIS_BITS-1:0]   ax [3][3];
   logic signed [OPND_WIDTH-1:0]  opnd [3];
   logic [AXIS_PACK_WIDTH-1:0]    axis_pack [3];
   logic signed [COORD_WIDTH-1:0] origin [3];

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [OP_WIDTH-1:0]           s1_op_ff;
   logic                          s1_add_origin_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff [3][3];
   logic signed [DOT_WIDTH-1:0]   dot_ff [3][3];

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   rsp_type                       rsp_data_ff;
   rsp_type                       rsp_data_in;

   logic                          s1_ready;
   logic                          s2_ready;

   // pipeline advance
   assign s2_ready   = !rsp_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign work_ready = s1_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign axis_pack[0] = cfg.axis_x;
   assign axis_pack[1] = cfg.axis_y;
   assign axis_pack[2] = cfg.axis_z;
   assign origin[0]    = cfg.origin_x;
   assign origin[1]    = cfg.origin_y;
   assign origin[2]    = cfg.origin_z;
   assign opnd[0]      = work_data.opnd_x;
   assign opnd[1]      = work_data.opnd_y;
   assign opnd[2]      = work_data.opnd_z;

   // unpack axis components
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) begin
            ax[a][c] = axis_comp(axis_pack[a], 2'(c));
         end
      end
   end

   // stage one: nine operand products and nine component products of adjacent axes
   for (genvar o = 0; o < 3; o++) begin : g_row
      localparam int NEXT_AXIS = (o + 1) % 3;
      for (genvar k = 0; k < 3; k++) begin : g_col
         logic signed [OPND_WIDTH-1:0] mul_a;
         logic signed [AXIS_BITS-1:0]  mul_b;
         logic signed [PROD_WIDTH-1:0] prod_in;
         logic signed [DOT_WIDTH-1:0]  dot_in;

         // world to local projects onto a row, local to world uses a column
         always_comb begin
            case (work_data.op)
               OP_W2L: begin
                  mul_a = opnd[k];
                  mul_b = ax[o][k];
               end
               OP_L2W: begin
                  mul_a = opnd[k];
                  mul_b = ax[k][o];
               end
               OP_CHECK: begin
                  mul_a = OPND_WIDTH'(ax[o][k]);
                  mul_b = ax[o][k];
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
            prod_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
            dot_in  = DOT_WIDTH'(ax[o][k]) * DOT_WIDTH'(ax[NEXT_AXIS][k]);
         end

         always_ff @(posedge clock) begin
            if (s1_ready) begin
               prod_ff[o][k] <= prod_in;
               dot_ff[o][k]  <= dot_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_op_ff         <= work_data.op;
         s1_add_origin_ff <= work_data.add_origin;
      end
   end

   assign s1_valid_in = s1_ready ? work_valid : s1_valid_ff;

   // stage two: sums, renormalize, origin, saturate, orthonormal tests
   always_comb begin
      logic signed [SUM_WIDTH-1:0]   sum;
      logic signed [SUM_WIDTH-1:0]   dsum;
      logic signed [SUM_WIDTH-1:0]   len_err;
      logic signed [SUM_WIDTH-1:0]   len_mag;
      logic signed [SUM_WIDTH-1:0]   dot_mag;
      logic signed [SUM_WIDTH-1:0]   tol_len;
      logic signed [ACC_WIDTH-1:0]   acc;
      logic signed [COORD_WIDTH-1:0] coord [3];
      logic [2:0]                    over;
      logic                          ok;

      tol_len = $signed(SUM_WIDTH'(cfg.tol) << AXIS_FRAC);
      ok      = 1'b1;
      over    = '0;
      for (int o = 0; o < 3; o++) begin
         sum  = SUM_WIDTH'(prod_ff[o][0]) + SUM_WIDTH'(prod_ff[o][1])
              + SUM_WIDTH'(prod_ff[o][2]);
         dsum = SUM_WIDTH'(dot_ff[o][0]) + SUM_WIDTH'(dot_ff[o][1])
              + SUM_WIDTH'(dot_ff[o][2]);

         // floor shift then optional origin
         acc = ACC_WIDTH'($signed(sum[SUM_WIDTH-1:AXIS_FRAC]))
             + (s1_add_origin_ff ? ACC_WIDTH'(origin[o]) : ACC_WIDTH'(0));
         over[o] = (acc[ACC_WIDTH-1:COORD_WIDTH-1] != '0)
                && (acc[ACC_WIDTH-1:COORD_WIDTH-1] != '1);
         if (over[o]) begin
            coord[o] = acc[ACC_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                        : {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end else begin
            coord[o] = acc[COORD_WIDTH-1:0];
         end

         // squared length against one, dot product against zero
         len_err = sum - (SUM_WIDTH'(1) << (2 * AXIS_FRAC));
         len_mag = (len_err < 0) ? -len_err : len_err;
         dot_mag = (dsum < 0) ? -dsum : dsum;
         if (len_mag > tol_len || dot_mag > tol_len) begin
            ok = 1'b0;
         end
      end

      rsp_data_in = '0;
      case (s1_op_ff)
         OP_W2L, OP_L2W: begin
            rsp_data_in.out_x     = coord[0];
            rsp_data_in.out_y     = coord[1];
            rsp_data_in.out_z     = coord[2];
            rsp_data_in.saturated = |over;
         end
         OP_CHECK: begin
            rsp_data_in.is_orthonormal = ok;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `FCT_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s2_ready, s1_valid_ff && $stable(s1_op_ff), "product stage lost its word under stall")
   `FCT_ASSERT_NEXT(a_s1_load, work_valid && work_ready, s1_valid_ff, "taken word missing from product stage")
   `FCT_ASSERT_SAME(a_check_zero, rsp_valid_ff && rsp_data_ff.is_orthonormal, rsp_data_ff.out_x == '0 && rsp_data_ff.out_y == '0 && rsp_data_ff.out_z == '0 && !rsp_data_ff.saturated, "check response carries coordinates")

endmodule

[hdl/frame_coordinate_transform.sv]
// top level of the frame coordinate transform
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_data: cmd, in_x, in_y, in_z
//   rsp_      out        rsp_valid/rsp_stall   rsp_data: out_x/y/z, saturated, is_orthonormal
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// one word per cycle sustained while rsp_stall stays low; a word taken on a free
// path passes the front register, queue, product stage and response register
// before it is shown on rsp; the back end forms 33x18 products in its product stage
// reset is synchronous; it clears handshake and queue state and loads the
// identity frame into the configuration registers
// a stalled response holds the back end; the queue lets the front keep
// taking words until it fills, then req_stall rises
module frame_coordinate_transform #(
   parameter int QUEUE_DEPTH = fct_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fct_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fct_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fct_pkg::AXIS_PACK_WIDTH-1:0] csr_wdata
);
   import fct_pkg::*;

   cfg_type  cfg;
   work_type front_word;
   work_type back_word;
   logic     front_valid;
   logic     queue_full;
   logic     back_valid;
   logic     back_ready;

   // configuration registers
   fct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // accept and classify
   fct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg),
      .work_full  (queue_full),
      .work_valid (front_valid),
      .work_data  (front_word)
   );

   // decoupling queue
   fct_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .full       (queue_full),
      .push_data  (front_word),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_word)
   );

   // arithmetic and response
   fct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (back_valid),
      .work_ready (back_ready),
      .work_data  (back_word),
      .cfg        (cfg),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
